// ----- hdl/assert_macros.svh -----
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication check, disabled while reset is low
`define GBS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that holds on every clock edge outside reset
`define GBS_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

// ----- hdl/gbs_pkg.sv -----
// shared types and constants for the greedy box suppression block
package gbs_pkg;

    localparam int MAX_KEPT = 64;
    localparam int IDX_W    = $clog2(MAX_KEPT);
    localparam int CNT_W    = 7;
    localparam int COORD_W  = 12;
    localparam int EDGE_W   = 14;
    localparam int SIZE_W   = 12;
    localparam int AREA_W   = 24;
    localparam int UNION_W  = 25;
    localparam int THR_W    = 9;
    localparam int PROD_W   = 34;

    localparam logic [THR_W-1:0] THR_RESET = 9'd115;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } gbs_state_t;

    // input tdata, first field in the highest bits
    typedef struct packed {
        logic [15:0]              score;
        logic [7:0]               class_label;
        logic [SIZE_W-1:0]        box_h;
        logic [SIZE_W-1:0]        box_w;
        logic signed [COORD_W-1:0] box_y;
        logic signed [COORD_W-1:0] box_x;
    } s_data_t;

    // result tdata, first field in the highest bits
    typedef struct packed {
        logic              pad;
        logic [CNT_W-1:0]  kept_total;
        logic [15:0]       out_score;
        logic [7:0]        out_label;
    } m_data_t;

    typedef struct packed {
        logic store_overflow;
        logic keep;
    } m_user_t;

    // stored box: corners and area
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [EDGE_W-1:0]  r;
        logic signed [EDGE_W-1:0]  b;
        logic [AREA_W-1:0]         area;
    } kept_entry_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
    } gbs_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic pipe_busy;
        logic out_busy;
    } gbs_stat_t;

endpackage

// ----- hdl/greedy_box_suppression.sv -----
// greedy box suppression top level: one box in, one keep/drop result out
// each box is taken, then the kept store is scanned and one kept box is read per cycle,
// then the overlap pipeline drains before the result is committed; an empty store skips
// the scan and drain, and the next box is taken only after the last result is committed
// a stalled result register adds its stall cycles before the next box is taken
// reset (aresetn low, synchronous) empties the kept list, threshold 115/256, store not cleared
module greedy_box_suppression (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,     // overlap_threshold
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,       // box_x, box_y, box_w, box_h, class_label, score
    input  logic        s_tuser,       // frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // out_label, out_score, kept_total, zero pad
    output logic [1:0]  m_tuser        // keep, store_overflow
);

    gbs_pkg::gbs_cmd_t  cmd;
    gbs_pkg::gbs_stat_t stat;

    gbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gbs_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- hdl/gbs_ctrl.sv -----
// controller state machine: accept, prepare, scan kept store, drain, commit; an empty store skips scan and drain
module gbs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  gbs_pkg::gbs_stat_t  stat,
    output gbs_pkg::gbs_cmd_t   cmd
);

    gbs_pkg::gbs_state_t state_reg;
    gbs_pkg::gbs_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gbs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gbs_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = gbs_pkg::ST_PREP;
            end
            gbs_pkg::ST_PREP: begin
                state_next = stat.count_zero ? gbs_pkg::ST_COMMIT : gbs_pkg::ST_SCAN;
            end
            gbs_pkg::ST_SCAN: begin
                if (stat.scan_last) state_next = gbs_pkg::ST_DRAIN;
            end
            gbs_pkg::ST_DRAIN: begin
                if (!stat.pipe_busy) state_next = gbs_pkg::ST_COMMIT;
            end
            gbs_pkg::ST_COMMIT: begin
                if (!stat.out_busy) state_next = gbs_pkg::ST_IDLE;
            end
            default: begin
                state_next = gbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.issue  = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            gbs_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            gbs_pkg::ST_SCAN: begin
                cmd.issue = 1'b1;
            end
            gbs_pkg::ST_COMMIT: begin
                cmd.commit = !stat.out_busy;
            end
            default: begin
                cmd.load = 1'b0;
            end
        endcase
    end

endmodule

// ----- hdl/gbs_datapath.sv -----
// datapath: kept store, overlap pipeline, counters and result register
module gbs_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  gbs_pkg::gbs_cmd_t                 cmd,
    output gbs_pkg::gbs_stat_t                stat,
    input  logic                              cfg_we,
    input  logic [gbs_pkg::THR_W-1:0]         cfg_wdata,
    input  logic [71:0]                       s_tdata,
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,
    output logic [1:0]                        m_tuser
);

    localparam int CW = gbs_pkg::COORD_W;
    localparam int EW = gbs_pkg::EDGE_W;
    localparam int SW = gbs_pkg::SIZE_W;
    localparam int AW = gbs_pkg::AREA_W;
    localparam int UW = gbs_pkg::UNION_W;
    localparam int PW = gbs_pkg::PROD_W;
    localparam int NW = gbs_pkg::CNT_W;
    localparam int IW = gbs_pkg::IDX_W;

    gbs_pkg::s_data_t     s_data;
    gbs_pkg::kept_entry_t mem [gbs_pkg::MAX_KEPT];
    gbs_pkg::kept_entry_t rd_entry_reg;
    gbs_pkg::kept_entry_t wr_entry;

    logic [gbs_pkg::THR_W-1:0] thr_reg;
    logic [NW-1:0]             count_reg;
    logic [NW-1:0]             count_next;
    logic [IW-1:0]             scan_idx_reg;

    logic signed [CW-1:0] cur_x_reg;
    logic signed [CW-1:0] cur_y_reg;
    logic signed [EW-1:0] cur_r_reg;
    logic signed [EW-1:0] cur_b_reg;
    logic [SW-1:0]        cur_w_reg;
    logic [SW-1:0]        cur_h_reg;
    logic [AW-1:0]        cur_area_reg;
    logic [7:0]           cur_label_reg;
    logic [15:0]          cur_score_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic signed [CW-1:0] ix1_reg, iy1_reg;
    logic signed [EW-1:0] ix2_reg, iy2_reg;
    logic [AW-1:0]        area2_reg, area3_reg, area4_reg;
    logic [SW-1:0]        iw_reg, ih_reg;
    logic [AW-1:0]        inter4_reg, inter5_reg, inter6_reg;
    logic [UW-1:0]        uni5_reg;
    logic [PW-1:0]        prod6_reg;
    logic                 suppress_reg;

    logic signed [CW-1:0] ix1_next, iy1_next;
    logic signed [EW-1:0] ix2_next, iy2_next;
    logic signed [EW:0]   iw_full, ih_full;
    logic [SW-1:0]        iw_next, ih_next;
    logic [UW-1:0]        uni_next;
    logic [PW-1:0]        prod_next;
    logic                 over_next;

    logic                 keep_c;
    logic                 full_c;
    logic                 store_c;

    gbs_pkg::m_data_t m_data_reg;
    gbs_pkg::m_user_t m_user_reg;
    logic             m_valid_reg;

    assign s_data = gbs_pkg::s_data_t'(s_tdata);

    // threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= gbs_pkg::THR_RESET;
        end else if (cfg_we) begin
            thr_reg <= cfg_wdata;
        end
    end

    // current box
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cur_x_reg     <= s_data.box_x;
            cur_y_reg     <= s_data.box_y;
            cur_r_reg     <= EW'(s_data.box_x) + $signed({2'b00, s_data.box_w}) - EW'(1);
            cur_b_reg     <= EW'(s_data.box_y) + $signed({2'b00, s_data.box_h}) - EW'(1);
            cur_w_reg     <= s_data.box_w;
            cur_h_reg     <= s_data.box_h;
            cur_label_reg <= s_data.class_label;
            cur_score_reg <= s_data.score;
        end
        cur_area_reg <= cur_w_reg * cur_h_reg;
    end

    // kept store
    assign wr_entry = '{x: cur_x_reg, y: cur_y_reg, r: cur_r_reg, b: cur_b_reg,
                        area: cur_area_reg};

    always_ff @(posedge aclk) begin
        if (cmd.commit && store_c) begin
            mem[count_reg[IW-1:0]] <= wr_entry;
        end
        if (cmd.issue) begin
            rd_entry_reg <= mem[scan_idx_reg];
        end
    end

    // overlap pipeline
    always_comb begin
        ix1_next = (rd_entry_reg.x > cur_x_reg) ? rd_entry_reg.x : cur_x_reg;
        iy1_next = (rd_entry_reg.y > cur_y_reg) ? rd_entry_reg.y : cur_y_reg;
        ix2_next = (rd_entry_reg.r < cur_r_reg) ? rd_entry_reg.r : cur_r_reg;
        iy2_next = (rd_entry_reg.b < cur_b_reg) ? rd_entry_reg.b : cur_b_reg;
        iw_full  = (EW+1)'(ix2_reg) - (EW+1)'(ix1_reg) + (EW+1)'(1);
        ih_full  = (EW+1)'(iy2_reg) - (EW+1)'(iy1_reg) + (EW+1)'(1);
        iw_next  = iw_full[EW] ? '0 : iw_full[SW-1:0];
        ih_next  = ih_full[EW] ? '0 : ih_full[SW-1:0];
        uni_next = {1'b0, cur_area_reg} + {1'b0, area4_reg} - {1'b0, inter4_reg};
        prod_next = {{(PW-gbs_pkg::THR_W){1'b0}}, thr_reg} * {{(PW-UW){1'b0}}, uni5_reg};
        over_next = {{(PW-AW-8){1'b0}}, inter6_reg, 8'h00} > prod6_reg;
    end

    always_ff @(posedge aclk) begin
        ix1_reg    <= ix1_next;
        iy1_reg    <= iy1_next;
        ix2_reg    <= ix2_next;
        iy2_reg    <= iy2_next;
        area2_reg  <= rd_entry_reg.area;
        iw_reg     <= iw_next;
        ih_reg     <= ih_next;
        area3_reg  <= area2_reg;
        inter4_reg <= iw_reg * ih_reg;
        area4_reg  <= area3_reg;
        uni5_reg   <= uni_next;
        inter5_reg <= inter4_reg;
        prod6_reg  <= prod_next;
        inter6_reg <= inter5_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            v6_reg       <= 1'b0;
            suppress_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            if (cmd.load) begin
                suppress_reg <= 1'b0;
            end else if (v6_reg && over_next) begin
                suppress_reg <= 1'b1;
            end
        end
    end

    // kept count and scan index
    assign keep_c  = !suppress_reg;
    assign full_c  = (count_reg == NW'(gbs_pkg::MAX_KEPT));
    assign store_c = keep_c && !full_c;

    always_comb begin
        count_next = count_reg;
        if (cmd.load && s_tuser) begin
            count_next = '0;
        end else if (cmd.commit && store_c) begin
            count_next = count_reg + NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            scan_idx_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (cmd.load) begin
                scan_idx_reg <= '0;
            end else if (cmd.issue) begin
                scan_idx_reg <= scan_idx_reg + IW'(1);
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_data_reg.pad             <= 1'b0;
            m_data_reg.kept_total      <= count_next;
            m_data_reg.out_score       <= cur_score_reg;
            m_data_reg.out_label       <= cur_label_reg;
            m_user_reg.keep            <= keep_c;
            m_user_reg.store_overflow  <= keep_c && full_c;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    assign stat.count_zero = (count_reg == '0);
    assign stat.scan_last  = ({1'b0, scan_idx_reg} == (count_reg - NW'(1)));
    assign stat.pipe_busy  = v1_reg | v2_reg | v3_reg | v4_reg | v5_reg | v6_reg;
    assign stat.out_busy   = m_valid_reg && !m_tready;

endmodule

// ----- hdl/gbs_checker.sv -----
// port-level checks for the greedy box suppression block, bound to the top level
`include "assert_macros.svh"

module gbs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    localparam logic [6:0] FULL_COUNT = 7'(gbs_pkg::MAX_KEPT);

    `GBS_ASSERT(a_result_held, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `GBS_ASSERT(a_one_box_at_a_time, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "second box taken while one is in work")
    `GBS_ASSERT(a_overflow_needs_keep, aclk, aresetn, m_tvalid && m_tuser[1] |-> m_tuser[0], "overflow on a dropped box")
    `GBS_ASSERT(a_overflow_when_full, aclk, aresetn, m_tvalid && m_tuser[1] |-> m_tdata[30:24] == FULL_COUNT, "overflow with room in store")
    `GBS_ASSERT_ALWAYS(a_count_range, aclk, aresetn, !m_tvalid || m_tdata[30:24] <= FULL_COUNT, "kept count beyond store size")

endmodule

bind greedy_box_suppression gbs_checker u_gbs_checker (.*);

// ----- bench/gbs_checker.sv -----
`timescale 1ns / 100ps
// checker for greedy box suppression: predicts every keep/drop verdict and compares results
module gbs_scoreboard (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,    // box_x, box_y, box_w, box_h, class_label, score
    input  logic        s_tuser,    // frame_start
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,    // out_label, out_score, kept_total, zero pad
    input  logic [1:0]  m_tuser,    // keep, store_overflow
    output int          fail_count,
    output int          outstanding,
    output int          kept_seen,
    output int          dropped_seen,
    output int          overflow_seen
);

    typedef struct {
        int x;
        int y;
        int w;
        int h;
    } box_geom_t;

    typedef struct {
        logic                      keep;
        logic [7:0]                label;
        logic [15:0]               score;
        logic [gbs_pkg::CNT_W-1:0] total;
        logic                      overflow;
    } verdict_t;

    box_geom_t                 kept_store [gbs_pkg::MAX_KEPT];
    int                        kept_n;
    logic [gbs_pkg::THR_W-1:0] threshold;
    verdict_t                  pending_verdicts [$];

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    // exact integer iou test, inclusive pixel edges
    function automatic bit too_close(input box_geom_t a, input box_geom_t b,
                                     input logic [gbs_pkg::THR_W-1:0] thr);
        longint ix1, iy1, ix2, iy2, iw, ih, inter, uni;
        ix1 = (a.x > b.x) ? a.x : b.x;
        iy1 = (a.y > b.y) ? a.y : b.y;
        ix2 = (a.x + a.w < b.x + b.w) ? a.x + a.w - 1 : b.x + b.w - 1;
        iy2 = (a.y + a.h < b.y + b.h) ? a.y + a.h - 1 : b.y + b.h - 1;
        iw = ix2 - ix1 + 1;
        ih = iy2 - iy1 + 1;
        if (iw < 0) iw = 0;
        if (ih < 0) ih = 0;
        inter = iw * ih;
        uni = longint'(a.w) * a.h + longint'(b.w) * b.h - inter;
        return inter * 256 > longint'(thr) * uni;
    endfunction

    function automatic verdict_t judge_box(input gbs_pkg::s_data_t d, input logic frame_start);
        box_geom_t cur;
        verdict_t  v;
        if (frame_start) kept_n = 0;
        cur.x = $signed(d.box_x);
        cur.y = $signed(d.box_y);
        cur.w = d.box_w;
        cur.h = d.box_h;
        v.keep = 1'b1;
        v.overflow = 1'b0;
        for (int i = 0; i < kept_n; i++) begin
            if (too_close(cur, kept_store[i], threshold)) v.keep = 1'b0;
        end
        if (v.keep) begin
            if (kept_n < gbs_pkg::MAX_KEPT) begin
                kept_store[kept_n] = cur;
                kept_n++;
            end else begin
                v.overflow = 1'b1;
            end
        end
        v.label = d.class_label;
        v.score = d.score;
        v.total = gbs_pkg::CNT_W'(kept_n);
        return v;
    endfunction

    always @(posedge aclk) begin
        gbs_pkg::m_data_t md;
        gbs_pkg::m_user_t mu;
        verdict_t         want;
        if (!aresetn) begin
            kept_n = 0;
            threshold = gbs_pkg::THR_RESET;
            pending_verdicts.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                md = m_tdata;
                mu = m_tuser;
                if (pending_verdicts.size() == 0) begin
                    report_mismatch($sformatf("result with no box pending, label %0d",
                                              md.out_label));
                end else begin
                    want = pending_verdicts.pop_front();
                    if (mu.keep !== want.keep)
                        report_mismatch($sformatf("keep %b, expected %b",
                                                  mu.keep, want.keep));
                    if (md.out_label !== want.label)
                        report_mismatch($sformatf("out_label %0d, expected %0d",
                                                  md.out_label, want.label));
                    if (md.out_score !== want.score)
                        report_mismatch($sformatf("out_score %0d, expected %0d",
                                                  md.out_score, want.score));
                    if (md.kept_total !== want.total)
                        report_mismatch($sformatf("kept_total %0d, expected %0d",
                                                  md.kept_total, want.total));
                    if (mu.store_overflow !== want.overflow)
                        report_mismatch($sformatf("store_overflow %b, expected %b",
                                                  mu.store_overflow, want.overflow));
                    if (!want.keep) dropped_seen++;
                    else if (want.overflow) overflow_seen++;
                    else kept_seen++;
                end
            end
            if (s_tvalid && s_tready)
                pending_verdicts = {pending_verdicts, judge_box(s_tdata, s_tuser)};
            if (cfg_we) threshold = cfg_wdata;
        end
        outstanding = pending_verdicts.size();
    end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// testbench top for greedy box suppression: box stimulus, result back-pressure and verdict
module tb;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [8:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    int fail_count;
    int outstanding;
    int kept_seen;
    int dropped_seen;
    int overflow_seen;
    int boxes_sent;
    int settings_used;
    bit hold_rx;

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    greedy_box_suppression i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    gbs_scoreboard i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .kept_seen     (kept_seen),
        .dropped_seen  (dropped_seen),
        .overflow_seen (overflow_seen)
    );

    initial begin
        #1_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic gbs_pkg::s_data_t make_box(input int x, input int y, input int w,
                                                  input int h, input int label,
                                                  input int score);
        gbs_pkg::s_data_t d;
        d.box_x = x[11:0];
        d.box_y = y[11:0];
        d.box_w = w[11:0];
        d.box_h = h[11:0];
        d.class_label = label[7:0];
        d.score = score[15:0];
        return d;
    endfunction

    task automatic send_box(input gbs_pkg::s_data_t d, input logic frame_start, input int gap);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= frame_start;
        do @(posedge aclk); while (!s_tready);
        boxes_sent++;
    endtask

    // stop offering and wait for every pending result
    task automatic settle(input int tail);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (tail) @(negedge aclk);
    endtask

    task automatic set_threshold(input logic [8:0] thr);
        settle(8);
        cfg_we    <= 1'b1;
        cfg_wdata <= thr;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // clustered boxes in falling score order; a broken scene skips or scatters frame starts
    task automatic send_scene(input int n, input bit broken);
        int cx [4];
        int cy [4];
        int nc;
        int c;
        int sc;
        logic fs;
        nc = $urandom_range(1, 4);
        for (int i = 0; i < nc; i++) begin
            cx[i] = $urandom_range(0, 3800) - 1900;
            cy[i] = $urandom_range(0, 3800) - 1900;
        end
        sc = $urandom_range(30000, 65535);
        for (int i = 0; i < n; i++) begin
            c = $urandom_range(0, nc - 1);
            fs = broken ? ($urandom_range(0, 9) == 0) : (i == 0);
            send_box(make_box(cx[c] + $urandom_range(0, 30) - 15,
                              cy[c] + $urandom_range(0, 30) - 15,
                              $urandom_range(8, 80), $urandom_range(8, 80),
                              $urandom_range(0, 15), sc), fs, pick_gap());
            sc -= $urandom_range(0, 400);
            if (sc < 0) sc = 0;
        end
    endtask

    initial begin
        int r;
        int n;
        m_tready = 1'b0;
        @(negedge aclk);
        forever begin
            if (hold_rx) begin
                m_tready <= 1'b0;
                repeat (400) @(negedge aclk);
                hold_rx = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    m_tready <= 1'b1;
                    n = $urandom_range(1, 8);
                end else if (r < 90) begin
                    m_tready <= 1'b0;
                    n = $urandom_range(1, 3);
                end else if (r < 97) begin
                    m_tready <= 1'b1;
                    n = $urandom_range(30, 100);
                end else begin
                    m_tready <= 1'b0;
                    n = $urandom_range(20, 80);
                end
                repeat (n) @(negedge aclk);
            end
        end
    end

    initial begin
        logic [8:0]  thr_list [6];
        logic [95:0] raw;
        int          phase_start;
        int          r;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        hold_rx   = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        settings_used = 1;

        // reset threshold: field extremes, empty-union pair, duplicate, partial overlaps
        send_box(make_box(-2048, -2048, 4095, 4095, 255, 65535), 1'b1, 0);
        send_box(make_box(2047, 2047, 1, 1, 0, 0), 1'b0, 0);
        send_box(make_box(0, 0, 0, 0, 17, 40000), 1'b0, 2);
        send_box(make_box(0, 0, 0, 0, 18, 39000), 1'b0, 0);
        send_box(make_box(2047, 2047, 1, 1, 19, 38000), 1'b0, 1);
        send_box(make_box(100, 100, 50, 50, 3, 30000), 1'b1, 0);
        send_box(make_box(110, 100, 50, 50, 3, 29000), 1'b0, 0);
        send_box(make_box(130, 100, 50, 50, 4, 28000), 1'b0, 0);

        // zero threshold: a single shared pixel suppresses
        set_threshold(9'd0);
        send_box(make_box(0, 0, 10, 10, 1, 5000), 1'b1, 0);
        send_box(make_box(9, 9, 10, 10, 2, 4000), 1'b0, 0);
        send_box(make_box(10, 10, 10, 10, 3, 3000), 1'b0, 0);

        // full threshold: nothing is suppressed
        set_threshold(9'd256);
        send_box(make_box(-5, -5, 20, 20, 7, 60000), 1'b1, 0);
        send_box(make_box(-5, -5, 20, 20, 7, 59000), 1'b0, 0);
        send_box(make_box(-5, -5, 20, 20, 170, 21845), 1'b0, 3);
        send_box(make_box(2047, -2048, 4095, 4095, 85, 43690), 1'b0, 0);

        set_threshold(9'd255);
        send_box(make_box(0, 0, 4095, 4095, 9, 1000), 1'b1, 0);
        send_box(make_box(0, 0, 4095, 4095, 9, 999), 1'b0, 0);

        thr_list = '{9'd115, 9'd1, 9'd64, 9'd200, 9'd255, 9'd0};
        thr_list[5] = $urandom_range(0, 256);
        for (int p = 0; p < 6; p++) begin
            set_threshold(thr_list[p]);
            phase_start = boxes_sent;
            if (p == 2) begin
                // tiled disjoint boxes fill the store, then duplicates and newcomers
                for (int i = 0; i < 72; i++)
                    send_box(make_box(-2000 + (i % 9) * 24, -2000 + (i / 9) * 24, 16, 16,
                                      i, 65535 - i), i == 0, 0);
                for (int i = 0; i < 8; i++)
                    send_box(make_box(-2000 + (i % 2) * 24 + 1000 * (i / 2 % 2),
                                      -2000, 16, 16, 200 + i, 100 - i), 1'b0, pick_gap());
            end
            if (p == 3) hold_rx = 1'b1;
            while (boxes_sent - phase_start < 55) begin
                r = $urandom_range(0, 9);
                if (r < 7) begin
                    send_scene($urandom_range(3, 16), 1'b0);
                end else if (r == 7) begin
                    send_scene($urandom_range(3, 16), 1'b1);
                end else begin
                    repeat ($urandom_range(1, 4)) begin
                        raw = {$urandom(), $urandom(), $urandom()};
                        send_box(raw[71:0], $urandom_range(0, 7) == 0, pick_gap());
                    end
                end
            end
            if (p == 1) settle(0);
        end

        settle(80);
        $display("covered %0d boxes under %0d threshold settings, with a full kept store",
                 boxes_sent, settings_used);
        $display("verdicts: %0d kept, %0d dropped, %0d kept but refused by the store",
                 kept_seen, dropped_seen, overflow_seen);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/gbs_pkg.sv
hdl/gbs_ctrl.sv
hdl/gbs_datapath.sv
hdl/greedy_box_suppression.sv
hdl/gbs_checker.sv
bench/gbs_checker.sv
bench/tb.sv
